[src/ntc_beta_temperature_converter_macros.svh]
// Assertion macros shared by the converter checker.
// No dependencies.
`ifndef NTC_BETA_TEMPERATURE_CONVERTER_MACROS_SVH
`define NTC_BETA_TEMPERATURE_CONVERTER_MACROS_SVH
// Implication checked on every clock edge outside reset
`define NTC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntc converter assertion failed");
// Next-cycle implication checked on every clock edge outside reset
`define NTC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntc converter assertion failed");
`endif

[src/ntc_pkg.sv]
// Package for the NTC beta converter: constants, stage types and status codes.
// No dependencies.
`default_nettype none
package ntc_pkg;
  localparam int unsigned ADC_FULL_SCALE_DEF = 1023;
  localparam logic [31:0] LN2_Q32    = 32'd2977044472;
  localparam logic [31:0] INV_T0_Q32 = 32'd14405391;
  localparam logic [31:0] KELVIN_OFS = 32'd17901158;
  localparam logic [15:0] FIXED_RST  = 16'd10000;
  localparam logic [15:0] NOMINAL_RST = 16'd10000;
  localparam logic [15:0] BETA_RST   = 16'd3950;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_SAT  = 2'd3;

  localparam logic [1:0] REG_FIXED   = 2'd0;
  localparam logic [1:0] REG_NOMINAL = 2'd1;
  localparam logic [1:0] REG_BETA    = 2'd2;

  // Side information carried along the pipeline
  typedef struct packed {
    logic       done;   // result already decided
    logic [1:0] status;
    logic [7:0] temp;
  } ntc_side_t;
endpackage
`default_nettype wire

[src/ntc_log2_pipe.sv]
// Pipelined log2 in Q8.24: one squaring step per stage, 24 stages.
// Depends on ntc_pkg.
`default_nettype none
module ntc_log2_pipe
  import ntc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] x,
  output logic [31:0]      y
);
  logic [4:0]  top;
  logic [32:0] m0;
  logic [32:0] m_r   [0:24];
  logic [4:0]  top_r [0:24];
  logic [23:0] fr_r  [0:24];

  // leading one search
  always_comb begin
    top = '0;
    for (int i = 0; i < 32; i++) if (x[i]) top = 5'(i);
    m0 = 33'({1'b0, x} << (5'd31 - top));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]   <= m0;
      top_r[0] <= top;
      fr_r[0]  <= '0;
    end
  end

  // one squaring per stage
  genvar g;
  generate
    for (g = 0; g < 24; g++) begin : g_sq
      logic [65:0] sq;
      logic [33:0] sh;
      assign sq = m_r[g] * m_r[g];
      assign sh = 34'(sq >> 31);
      always_ff @(posedge clk) begin
        if (en) begin
          top_r[g+1] <= top_r[g];
          if (sh[32]) begin
            m_r[g+1]  <= 33'(sh >> 1);
            fr_r[g+1] <= {fr_r[g][22:0], 1'b1};
          end else begin
            m_r[g+1]  <= sh[32:0];
            fr_r[g+1] <= {fr_r[g][22:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign y = {3'b000, top_r[24], fr_r[24]};
endmodule
`default_nettype wire

[src/ntc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ntc_pkg.
`default_nettype none
module ntc_div_pipe
  import ntc_pkg::*;
#(
  parameter int NW = 49,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic [NW-1:0]      quo
);
  logic [NW-1:0] n_r [0:NW];
  logic [DW-1:0] d_r [0:NW];
  logic [DW:0]   r_r [0:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= num;
      d_r[0] <= den;
      r_r[0] <= '0;
    end
  end

  genvar g;
  generate
    for (g = 0; g < NW; g++) begin : g_st
      logic [DW+1:0] t;
      assign t = {r_r[g], n_r[g][NW-1]};
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[g+1] <= d_r[g];
          if (t >= {2'b00, d_r[g]}) begin
            r_r[g+1] <= (DW+1)'(t - {2'b00, d_r[g]});
            n_r[g+1] <= {n_r[g][NW-2:0], 1'b1};
          end else begin
            r_r[g+1] <= t[DW:0];
            n_r[g+1] <= {n_r[g][NW-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  assign quo = n_r[NW];
endmodule
`default_nettype wire

[src/ntc_beta_temperature_converter.sv]
// NTC beta converter: ADC code in, whole degrees Celsius and status out.
// Pipeline: 1+25+2+42+2+50+1 = 123 register stages from accept to out_valid.
// Throughput: one transaction per cycle; the whole pipeline stalls while out_valid is high and out_ready low.
// Reset: synchronous active-low rst_n clears valid bits and reloads the configuration registers.
// Depends on ntc_pkg, ntc_log2_pipe, ntc_div_pipe.
`default_nettype none
module ntc_beta_temperature_converter
  import ntc_pkg::*;
#(
  parameter int ADC_FULL_SCALE = ADC_FULL_SCALE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [9:0]  in_adc_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [7:0] out_temperature_c,
  output logic [1:0]       out_status,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int LAT = 122;
  localparam logic [16:0] FULL = 17'(ADC_FULL_SCALE);

  // 1/T range check codes
  localparam logic [1:0] RC_OK   = 2'd0;
  localparam logic [1:0] RC_HOT  = 2'd1;
  localparam logic [1:0] RC_COLD = 2'd2;

  logic [15:0] fixed_r, nominal_r, beta_r;
  logic        en;
  logic [LAT-1:0] vld_r;
  ntc_side_t   side_r [0:LAT-1];

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fixed_r <= FIXED_RST; nominal_r <= NOMINAL_RST; beta_r <= BETA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIXED:   fixed_r <= cfg_data;
        REG_NOMINAL: nominal_r <= cfg_data;
        REG_BETA:    beta_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 0: products and early decisions
  logic [31:0] num_r, den_r;
  ntc_side_t   s0;
  logic [31:0] num_c, den_c;
  always_comb begin
    num_c = 32'(fixed_r * in_adc_code);
    den_c = 32'((FULL - 17'(in_adc_code)) * nominal_r);
    s0 = '{done: 1'b0, status: ST_OK, temp: 8'd0};
    if (in_adc_code == 10'd0) s0 = '{1'b1, ST_ZERO, 8'd0};
    else if (17'(in_adc_code) >= FULL) s0 = '{1'b1, ST_FULL, 8'd0};
    else if (nominal_r == 16'd0) s0 = '{1'b1, ST_SAT, 8'h80};
    else if (fixed_r == 16'd0) s0 = '{1'b1, ST_SAT, 8'h7f};
    if (num_c == 0) num_c = 32'd1;
    if (den_c == 0) den_c = 32'd1;
  end
  always_ff @(posedge clk) begin
    if (en) begin num_r <= num_c; den_r <= den_c; end
  end

  // valid and side shift line
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_valid};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= s0;
      for (int i = 1; i < LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  // beta follows the item (config must only change when idle; the block does not enforce it, so a simple line)
  logic [15:0] b_r [0:27];
  always_ff @(posedge clk) begin
    if (en) begin
      b_r[0] <= (beta_r == 16'd0) ? 16'd1 : beta_r;
      for (int i = 1; i < 28; i++) b_r[i] <= b_r[i-1];
    end
  end

  // stages 1..25: log2
  logic [31:0] ln_num, ln_den;
  ntc_log2_pipe u_lnum (.clk, .en, .x(num_r), .y(ln_num));
  ntc_log2_pipe u_lden (.clk, .en, .x(den_r), .y(ln_den));

  // stage 26: difference magnitude; 27: times ln2, rounded
  logic        neg1_r, neg2_r;
  logic [31:0] dmag_r;
  logic [63:0] prod_r;
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= ln_num < ln_den;
      dmag_r <= (ln_num < ln_den) ? ln_den - ln_num : ln_num - ln_den;
      neg2_r <= neg1_r;
      prod_r <= dmag_r * LN2_Q32;
    end
  end
  logic [31:0] lnmag;
  assign lnmag = 32'((prod_r + 64'h8000_0000) >> 32);

  // stages 28..69: |ln|*256 + b/2 divided by beta (41 bit quotient)
  logic [40:0] tq;
  ntc_div_pipe #(.NW(41), .DW(16)) u_tdiv (
    .clk, .en,
    .num(41'({lnmag, 8'd0}) + 41'(b_r[27] >> 1)),
    .den(b_r[27]), .quo(tq));
  logic neg_l [0:41];
  always_ff @(posedge clk) begin
    if (en) begin
      neg_l[0] <= neg2_r;
      for (int i = 1; i < 42; i++) neg_l[i] <= neg_l[i-1];
    end
  end

  // stages 70..71: form 1/T and range checks
  logic signed [42:0] inv_r;
  logic               neg_a_r;
  logic [31:0]        invd_r;
  logic [1:0]         rc_r, rc2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      inv_r <= neg_l[41] ? 43'(signed'({2'b00, INV_T0_Q32})) - signed'({2'b00, tq})
                         : 43'(signed'({2'b00, INV_T0_Q32})) + signed'({2'b00, tq});
      if (inv_r <= 0) rc_r <= RC_HOT;
      else if (inv_r >= 43'sh1_0000_0000) rc_r <= RC_COLD;
      else rc_r <= RC_OK;
      invd_r <= (inv_r <= 0 || inv_r >= 43'sh1_0000_0000) ? 32'd1 : inv_r[31:0];
      rc2_r <= rc_r;
    end
  end
  assign neg_a_r = 1'b0;

  // stages 72..121: 2^48 / inv
  logic [48:0] tk;
  ntc_div_pipe #(.NW(49), .DW(32)) u_kdiv (
    .clk, .en, .num(49'h1_0000_0000_0000), .den(invd_r), .quo(tk));
  logic [1:0] rc_l [0:48];
  always_ff @(posedge clk) begin
    if (en) begin
      rc_l[0] <= rc2_r;
      for (int i = 1; i < 49; i++) rc_l[i] <= rc_l[i-1];
    end
  end

  // after stage 121: celsius, truncated toward zero, saturated
  logic signed [49:0] cq;
  logic signed [34:0] t;
  ntc_side_t          fin;
  always_comb begin
    cq = signed'({1'b0, tk}) - 50'(KELVIN_OFS);
    t  = cq[49] ? -35'(signed'({1'b0, 34'((-cq) >>> 16)}))
                : 35'(signed'({1'b0, 34'(cq >>> 16)}));
    fin = side_r[LAT-1];
    if (!fin.done) begin
      if (rc_l[48] == RC_HOT || neg_a_r) fin = '{1'b1, ST_SAT, 8'h7f};
      else if (rc_l[48] == RC_COLD) fin = '{1'b1, ST_SAT, 8'h80};
      else if (t > 35'sd127) fin = '{1'b1, ST_SAT, 8'h7f};
      else if (t < -35'sd128) fin = '{1'b1, ST_SAT, 8'h80};
      else fin = '{1'b1, ST_OK, t[7:0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (en) out_valid <= vld_r[LAT-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin out_temperature_c <= signed'(fin.temp); out_status <= fin.status; end
  end
endmodule
`default_nettype wire

[src/ntc_chk.sv]
// Port checker for the NTC converter, bound to the top level.
// Depends on the macro header and ntc_pkg.
`default_nettype none
`include "ntc_beta_temperature_converter_macros.svh"
module ntc_chk
  import ntc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_temperature_c,
  input wire logic [1:0] out_status
);
  `NTC_ASSERT_IMP(a_zero_temp, clk, rst_n, out_valid && (out_status == ST_ZERO || out_status == ST_FULL), out_temperature_c == 8'd0)
  `NTC_ASSERT_IMP(a_sat_rail, clk, rst_n, out_valid && out_status == ST_SAT, out_temperature_c == 8'h7f || out_temperature_c == 8'h80)
  `NTC_ASSERT_IMP(a_ready, clk, rst_n, out_valid && !out_ready, !in_ready)
  `NTC_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status))
endmodule
bind ntc_beta_temperature_converter ntc_chk u_chk (.*);
`default_nettype wire
